// File: rtl/etlc_pkg.sv
package etlc_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned OFFS_W  = 17;
    localparam int unsigned EPOCH_W = 32;

    localparam logic [33:0] LIMIT_SECONDS = 34'd4102444800;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;

    // reciprocal constants, ceil(2^k / d), exact over the operand ranges used
    localparam int unsigned K_675  = 35;
    localparam int unsigned K_1461 = 27;
    localparam int unsigned K_365  = 25;
    localparam int unsigned K_60   = 23;
    localparam int unsigned K_7    = 19;

    localparam longint unsigned RCP_675  = ((64'd1 << K_675) + 64'd674) / 64'd675;
    localparam longint unsigned RCP_1461 = ((64'd1 << K_1461) + 64'd1460) / 64'd1461;
    localparam longint unsigned RCP_365  = ((64'd1 << K_365) + 64'd364) / 64'd365;
    localparam longint unsigned RCP_60   = ((64'd1 << K_60) + 64'd59) / 64'd60;
    localparam longint unsigned RCP_7    = ((64'd1 << K_7) + 64'd6) / 64'd7;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DOY_W-1:0]   start;
    } t_month;

    function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] idx);
        logic [DOY_W-1:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        if (leap && idx >= 4'd2) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: rtl/etlc_month.sv
module etlc_month (
    input  logic [etlc_pkg::DOY_W-1:0] i_doy,
    input  logic                       i_leap,
    output etlc_pkg::t_month           o_month
);
    import etlc_pkg::*;

    always_comb begin
        o_month.month = 4'd1;
        o_month.start = '0;
        for (int i = 1; i < 12; i++) begin
            if (i_doy >= month_start(i_leap, 4'(i))) begin
                o_month.month = 4'(i + 1);
                o_month.start = month_start(i_leap, 4'(i));
            end
        end
    end

endmodule

// File: rtl/epoch_to_local_calendar.sv
// a result is valid once its request has passed register stages a to g, in order
// throughput: one request per cycle while the output is not stalled, seven register stages with a common stall
// the stall follows the output stage: the pipe holds while a result waits
// reset (synchronous, active low) clears all stage valid bits and loads
// the zone offset with +9 hours (32400 s)
module epoch_to_local_calendar (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic signed [etlc_pkg::OFFS_W-1:0]    i_cfg_wr_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [etlc_pkg::EPOCH_W-1:0]          i_epoch_seconds,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [etlc_pkg::YEAR_W-1:0]           o_year,
    output logic [etlc_pkg::MONTH_W-1:0]          o_month,
    output logic [etlc_pkg::DOM_W-1:0]            o_day_of_month,
    output logic [etlc_pkg::DOY_W-1:0]            o_day_of_year,
    output logic [etlc_pkg::HOUR_W-1:0]           o_hour,
    output logic [etlc_pkg::MIN_W-1:0]            o_minute,
    output logic [etlc_pkg::SEC_W-1:0]            o_second,
    output logic [etlc_pkg::WDAY_W-1:0]           o_weekday,
    output logic                                  o_range_error
);
    import etlc_pkg::*;

    localparam int unsigned NSTG = 7;

    logic signed [OFFS_W-1:0] r_offset;
    logic [NSTG-1:0]          r_vld;
    logic [NSTG-1:0]          r_err;
    logic                     en;

    // stage a: local seconds and range check
    logic signed [33:0] n_lt;
    logic               n_err;
    logic [31:0]        r_a_t;

    // stage b: day count
    logic [50:0] b_prod;
    logic [15:0] r_b_days;
    logic [24:0] r_b_q1;
    logic [6:0]  r_b_r1;

    // stage c: second of day, leap days, week quotient
    logic [25:0] c_dprod;
    logic [25:0] c_rem;
    logic [16:0] c_lx;
    logic [16:0] c_wx;
    logic [33:0] c_lprod;
    logic [33:0] c_wprod;
    logic [15:0] r_c_days;
    logic [16:0] r_c_sod;
    logic [5:0]  r_c_leap;
    logic [13:0] r_c_wq;

    // stage d: minute count, year offset, weekday
    logic [34:0] d_mprod;
    logic [15:0] d_dl;
    logic [32:0] d_yprod;
    logic [16:0] d_wd;
    logic [15:0] r_d_days;
    logic [16:0] r_d_sod;
    logic [10:0] r_d_mt;
    logic [7:0]  r_d_y;
    logic [2:0]  r_d_wd;

    // stage e: second, hour, day of year
    logic [16:0] e_sec;
    logic [28:0] e_hprod;
    logic [15:0] e_ybase;
    logic [15:0] e_doy;
    logic [5:0]  r_e_sec;
    logic [10:0] r_e_mt;
    logic [4:0]  r_e_hr;
    logic [8:0]  r_e_doy;
    logic        r_e_leap;
    logic [7:0]  r_e_y;
    logic [2:0]  r_e_wd;

    // stage f: minute and month
    logic [10:0] f_min;
    t_month      f_mon;
    logic [5:0]  r_f_sec;
    logic [5:0]  r_f_min;
    logic [4:0]  r_f_hr;
    logic [8:0]  r_f_doy;
    logic [7:0]  r_f_y;
    logic [2:0]  r_f_wd;
    logic [3:0]  r_f_mon;
    logic [8:0]  r_f_start;

    // stage g: output register
    logic [8:0]  g_dom;
    logic [11:0] r_g_year;
    logic [3:0]  r_g_mon;
    logic [4:0]  r_g_dom;
    logic [8:0]  r_g_doy;
    logic [4:0]  r_g_hr;
    logic [5:0]  r_g_min;
    logic [5:0]  r_g_sec;
    logic [2:0]  r_g_wd;

    assign en         = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 17'sd32400;
        end else if (i_cfg_wr_en) begin
            r_offset <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_err <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
            r_err <= {r_err[NSTG-2:0], n_err};
        end
    end

    always_comb begin
        n_lt  = $signed({2'b00, i_epoch_seconds}) + 34'(r_offset);
        n_err = n_lt[33] || (n_lt >= $signed(LIMIT_SECONDS));
    end

    assign b_prod = 51'(r_a_t[31:7]) * 51'(RCP_675);

    always_comb begin
        c_dprod = 26'(r_b_days) * 26'd675;
        c_rem   = 26'(r_b_q1) - c_dprod;
        c_lx    = 17'(r_b_days) + 17'd672;
        c_wx    = 17'(r_b_days) + 17'd4;
        c_lprod = 34'(c_lx) * 34'(RCP_1461);
        c_wprod = 34'(c_wx) * 34'(RCP_7);
    end

    always_comb begin
        d_mprod = 35'(r_c_sod) * 35'(RCP_60);
        d_dl    = r_c_days - 16'(r_c_leap);
        d_yprod = 33'(d_dl) * 33'(RCP_365);
        d_wd    = (17'(r_c_days) + 17'd4) - 17'(r_c_wq) * 17'd7;
    end

    always_comb begin
        e_sec   = r_d_sod - 17'(r_d_mt) * 17'd60;
        e_hprod = 29'(r_d_mt) * 29'(RCP_60);
        e_ybase = 16'(r_d_y) * 16'd365 + 16'((9'(r_d_y) + 9'd1) >> 2);
        e_doy   = r_d_days - e_ybase;
    end

    assign f_min = r_e_mt - 11'(r_e_hr) * 11'd60;

    etlc_month u_month (
        .i_doy   (r_e_doy),
        .i_leap  (r_e_leap),
        .o_month (f_mon)
    );

    assign g_dom = r_f_doy - r_f_start + 9'd1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_t     <= n_lt[31:0];

            r_b_days  <= b_prod[K_675+15:K_675];
            r_b_q1    <= r_a_t[31:7];
            r_b_r1    <= r_a_t[6:0];

            r_c_days  <= r_b_days;
            r_c_sod   <= {c_rem[9:0], r_b_r1};
            r_c_leap  <= c_lprod[K_1461+5:K_1461];
            r_c_wq    <= c_wprod[K_7+13:K_7];

            r_d_days  <= r_c_days;
            r_d_sod   <= r_c_sod;
            r_d_mt    <= d_mprod[K_60+10:K_60];
            r_d_y     <= d_yprod[K_365+7:K_365];
            r_d_wd    <= d_wd[2:0];

            r_e_sec   <= e_sec[5:0];
            r_e_mt    <= r_d_mt;
            r_e_hr    <= e_hprod[K_60+4:K_60];
            r_e_doy   <= e_doy[8:0];
            r_e_leap  <= (r_d_y[1:0] == 2'd2);
            r_e_y     <= r_d_y;
            r_e_wd    <= r_d_wd;

            r_f_sec   <= r_e_sec;
            r_f_min   <= f_min[5:0];
            r_f_hr    <= r_e_hr;
            r_f_doy   <= r_e_doy;
            r_f_y     <= r_e_y;
            r_f_wd    <= r_e_wd;
            r_f_mon   <= f_mon.month;
            r_f_start <= f_mon.start;

            // out of range results carry zeros
            if (r_err[NSTG-2]) begin
                r_g_year <= '0;
                r_g_mon  <= '0;
                r_g_dom  <= '0;
                r_g_doy  <= '0;
                r_g_hr   <= '0;
                r_g_min  <= '0;
                r_g_sec  <= '0;
                r_g_wd   <= '0;
            end else begin
                r_g_year <= 12'(r_f_y) + EPOCH_YEAR;
                r_g_mon  <= r_f_mon;
                r_g_dom  <= g_dom[4:0];
                r_g_doy  <= r_f_doy;
                r_g_hr   <= r_f_hr;
                r_g_min  <= r_f_min;
                r_g_sec  <= r_f_sec;
                r_g_wd   <= r_f_wd;
            end
        end
    end

    assign o_out_valid    = r_vld[NSTG-1];
    assign o_range_error  = r_err[NSTG-1];
    assign o_year         = r_g_year;
    assign o_month        = r_g_mon;
    assign o_day_of_month = r_g_dom;
    assign o_day_of_year  = r_g_doy;
    assign o_hour         = r_g_hr;
    assign o_minute       = r_g_min;
    assign o_second       = r_g_sec;
    assign o_weekday      = r_g_wd;

endmodule

// File: verif/epoch_to_local_calendar_test.sv
module epoch_to_local_calendar_test;
    import etlc_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   day_of_month;
        logic [DOY_W-1:0]   day_of_year;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  weekday;
        logic               range_error;
    } t_calendar;

    localparam longint LIMIT_LOCAL = 64'sd4102444800;
    localparam longint DAY_SECONDS = 86400;
    localparam int unsigned MAX_CYCLES = 400000;
    localparam logic signed [OFFS_W-1:0] ZONE_WEST_MOST = -17'sd43200;
    localparam logic signed [OFFS_W-1:0] ZONE_EAST_MOST = 17'sd50400;
    localparam logic signed [OFFS_W-1:0] ZONE_UTC       = 17'sd0;
    localparam logic signed [OFFS_W-1:0] ZONE_RAW_MIN   = 17'h10000;
    localparam logic signed [OFFS_W-1:0] ZONE_RAW_MAX   = 17'h0FFFF;
    localparam int unsigned ITEMS_PER_PHASE = 200;

    class calendar_scoreboard;
        logic signed [OFFS_W-1:0] zone_offset;
        t_calendar expected_dates[$];
        int unsigned failures;

        function new();
            zone_offset = 17'sd32400;
            failures = 0;
        endfunction

        static function bit is_leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function t_calendar civil_time_of(logic [EPOCH_W-1:0] epoch);
            t_calendar r;
            longint local_s;
            int unsigned t, days, leap_days, y, doy, yr, m, start, len, dom, zy, zm;
            int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            r = '0;
            local_s = longint'(epoch) + longint'(zone_offset);
            if (local_s < 0 || local_s >= LIMIT_LOCAL) begin
                r.range_error = 1'b1;
                return r;
            end
            t = 32'(local_s);
            days = t / 86400;
            leap_days = (days + 672) / 1461;
            y = (days - leap_days) / 365;
            doy = days - (y * 365 + (y + 1) / 4);
            yr = y + 1970;
            start = 0;
            for (m = 1; m < 12; m++) begin
                len = month_len[m-1];
                if (m == 2 && is_leap_year(yr)) begin
                    len = 29;
                end
                if (doy < start + len) break;
                start += len;
            end
            dom = doy - start + 1;
            zm = m;
            zy = yr;
            if (m <= 2) begin
                zm = m + 12;
                zy = yr - 1;
            end
            r.year         = 12'(yr);
            r.month        = 4'(m);
            r.day_of_month = 5'(dom);
            r.day_of_year  = 9'(doy);
            r.hour         = 5'((t / 3600) % 24);
            r.minute       = 6'((t / 60) % 60);
            r.second       = 6'(t % 60);
            r.weekday      = 3'((dom + 13 * (zm + 1) / 5 + zy + zy / 4 - zy / 100 + zy / 400 + 6)
                                % 7);
            return r;
        endfunction

        function void note_request(logic [EPOCH_W-1:0] epoch);
            expected_dates.push_back(civil_time_of(epoch));
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_calendar got);
            t_calendar want;
            if (expected_dates.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
                return;
            end
            want = expected_dates.pop_front();
            compare_field("year", 32'(want.year), 32'(got.year));
            compare_field("month", 32'(want.month), 32'(got.month));
            compare_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
            compare_field("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
            compare_field("hour", 32'(want.hour), 32'(got.hour));
            compare_field("minute", 32'(want.minute), 32'(got.minute));
            compare_field("second", 32'(want.second), 32'(got.second));
            compare_field("weekday", 32'(want.weekday), 32'(got.weekday));
            compare_field("range_error", 32'(want.range_error), 32'(got.range_error));
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic signed [OFFS_W-1:0] i_cfg_wr_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [EPOCH_W-1:0]       i_epoch_seconds;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [YEAR_W-1:0]        o_year;
    logic [MONTH_W-1:0]       o_month;
    logic [DOM_W-1:0]         o_day_of_month;
    logic [DOY_W-1:0]         o_day_of_year;
    logic [HOUR_W-1:0]        o_hour;
    logic [MIN_W-1:0]         o_minute;
    logic [SEC_W-1:0]         o_second;
    logic [WDAY_W-1:0]        o_weekday;
    logic                     o_range_error;

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned cycle_count = 0;
    calendar_scoreboard sb = new();

    epoch_to_local_calendar uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_epoch_seconds (i_epoch_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_day_of_year   (o_day_of_year),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday),
        .o_range_error   (o_range_error)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("epoch_to_local_calendar_test failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                sb.check_result('{o_year, o_month, o_day_of_month, o_day_of_year, o_hour,
                                  o_minute, o_second, o_weekday, o_range_error});
            end
        end
    end

    function automatic longint jan_first(int unsigned year);
        longint days;
        days = 0;
        for (int unsigned y = 1970; y < year; y++) begin
            days += calendar_scoreboard::is_leap_year(y) ? 366 : 365;
        end
        return days * DAY_SECONDS;
    endfunction

    function automatic logic [EPOCH_W-1:0] epoch_for(longint local_s);
        return 32'(local_s - longint'(sb.zone_offset));
    endfunction

    function automatic logic [EPOCH_W-1:0] next_epoch();
        int unsigned pick;
        longint local_s;
        int unsigned day_marks[8] = '{0, 30, 31, 58, 59, 60, 364, 365};
        pick = $urandom_range(99);
        if (pick < 55) begin
            return $urandom;
        end
        if (pick < 70) begin
            local_s = (pick < 63) ? LIMIT_LOCAL : 64'sd0;
            return epoch_for(local_s + longint'($urandom_range(7200)) - 3600);
        end
        // edges of years, months and leap days
        local_s = jan_first($urandom_range(2100, 1970))
                  + longint'(day_marks[$urandom_range(7)]) * DAY_SECONDS;
        case ($urandom_range(2))
            0: local_s += 0;
            1: local_s += DAY_SECONDS - 1;
            default: local_s += longint'($urandom_range(86399));
        endcase
        return epoch_for(local_s);
    endfunction

    task automatic send_request(input logic [EPOCH_W-1:0] epoch);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_epoch_seconds <= epoch;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_request(epoch);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_zone_offset(input logic signed [OFFS_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.zone_offset = value;
    endtask

    initial begin
        logic signed [OFFS_W-1:0] phase_offset;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_epoch_seconds = '0;
        i_out_ready = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // offset from reset
        send_request(32'd0);
        send_request(32'hFFFF_FFFF);
        send_request(epoch_for(LIMIT_LOCAL - 1));
        send_request(epoch_for(LIMIT_LOCAL));
        send_request(epoch_for(jan_first(2000) + 59 * DAY_SECONDS));
        send_request(epoch_for(jan_first(2001) - 1));
        send_request(epoch_for(jan_first(2097) - 1));
        send_request(epoch_for(jan_first(2099) + 59 * DAY_SECONDS - 1));
        send_request(epoch_for(jan_first(2099) + 59 * DAY_SECONDS));
        send_request(32'h7FFF_FFFF);
        send_request(32'h8000_0000);

        // most westerly zone: local time below zero
        wait_for_results();
        write_zone_offset(ZONE_WEST_MOST);
        send_request(32'd0);
        send_request(32'd43199);
        send_request(32'd43200);
        send_request(epoch_for(jan_first(1972) + 59 * DAY_SECONDS));

        // most easterly zone: end of range
        wait_for_results();
        write_zone_offset(ZONE_EAST_MOST);
        send_request(epoch_for(LIMIT_LOCAL - 1));
        send_request(epoch_for(LIMIT_LOCAL));
        send_request(32'hFFFF_FFFF);

        wait_for_results();
        write_zone_offset(ZONE_UTC);
        send_request(32'd0);
        send_request(epoch_for(LIMIT_LOCAL - DAY_SECONDS));

        for (int unsigned phase = 0; phase < 5; phase++) begin
            case (phase)
                0: phase_offset = ZONE_WEST_MOST;
                1: phase_offset = ZONE_EAST_MOST;
                2: phase_offset = ZONE_RAW_MIN;
                3: phase_offset = ZONE_RAW_MAX;
                default: phase_offset = 17'($urandom_range(131071));
            endcase
            case (phase)
                1: begin
                    sender_idle_pct = 45;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 45;
                end
                3: begin
                    sender_idle_pct = 21;
                    receiver_stall_pct = 21;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            wait_for_results();
            write_zone_offset(phase_offset);
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long hold-off at the output so the pipe backs up
                if (phase == 0 && n == 60) begin
                    hold_cycles = 300;
                end
                if (phase == 2 && n == 100) begin
                    wait_for_results();
                end
                send_request(next_epoch());
            end
        end

        wait_for_results();
        repeat (20) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("epoch_to_local_calendar_test passed");
        end else begin
            $display("epoch_to_local_calendar_test failed");
        end
        $finish;
    end

endmodule
